[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define AST_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define AST_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[src/fpa_pkg.sv]
package fpa_pkg;

	localparam int FRAC_BITS  = 8;
	localparam int DATA_W     = 32;
	localparam int WIDE_W     = 2 * DATA_W;
	localparam int NUM_W      = DATA_W + FRAC_BITS;
	localparam int DIV_BITS   = 2;
	localparam int DIV_STAGES = (NUM_W + DIV_BITS - 1) / DIV_BITS;
	localparam int NUM_PAD_W  = DIV_STAGES * DIV_BITS;

	localparam logic [WIDE_W-1:0] POS_MAX  = WIDE_W'(32'h7FFF_FFFF);
	localparam logic [WIDE_W-1:0] NEG_MAG  = WIDE_W'(32'h8000_0000);
	localparam logic [WIDE_W-1:0] ROUND_HALF = WIDE_W'(1) << (FRAC_BITS - 1);

	typedef enum logic [3:0] {
		OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LT, OP_GT, OP_LE, OP_GE,
		OP_EQ, OP_NE, OP_MIN, OP_MAX, OP_INC, OP_DEC, OP_TO_INT, OP_FROM_INT
	} op_t;

	typedef struct packed {
		logic [3:0]               operation;
		logic signed [DATA_W-1:0] operand_a;
		logic signed [DATA_W-1:0] operand_b;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result_value;
		logic                     compare_true;
		logic                     saturated;
		logic                     divide_by_zero;
	} rsp_t;

	typedef struct packed {
		op_t               op;
		logic [DATA_W-1:0] simple;
		logic              cmp;
		logic              neg;
		logic              dz;
	} side_t;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              sat;
	} clamp_t;

	// Applies the sign to a magnitude and clamps it to the signed 32-bit range.
	function automatic clamp_t clamp_mag(input logic neg, input logic [WIDE_W-1:0] q);
		clamp_t c;
		c.sat = 1'b0;
		if (!neg) begin
			if (q > POS_MAX) begin
				c.sat   = 1'b1;
				c.value = POS_MAX[DATA_W-1:0];
			end else begin
				c.value = q[DATA_W-1:0];
			end
		end else begin
			if (q > NEG_MAG) begin
				c.sat   = 1'b1;
				c.value = NEG_MAG[DATA_W-1:0];
			end else begin
				c.value = DATA_W'(0) - q[DATA_W-1:0];
			end
		end
		return c;
	endfunction

endpackage

[src/fpa_div.sv]
module fpa_div (
	input  logic                           clk,
	input  logic                           en,
	input  logic [fpa_pkg::NUM_W-1:0]      num,
	input  logic [fpa_pkg::DATA_W-1:0]     den,
	output logic [fpa_pkg::NUM_PAD_W-1:0]  quot,
	output logic [fpa_pkg::DATA_W-1:0]     rem,
	output logic [fpa_pkg::DATA_W-1:0]     den_out
);

	typedef struct packed {
		logic [fpa_pkg::NUM_PAD_W-1:0] num;
		logic [fpa_pkg::NUM_PAD_W-1:0] quo;
		logic [fpa_pkg::DATA_W-1:0]    rem;
		logic [fpa_pkg::DATA_W-1:0]    den;
	} step_t;

	function automatic step_t div_step(input step_t s);
		step_t t;
		logic [fpa_pkg::DATA_W:0] trial;
		t = s;
		for (int i = 0; i < fpa_pkg::DIV_BITS; i++) begin
			trial = {t.rem, t.num[fpa_pkg::NUM_PAD_W-1]};
			t.num = {t.num[fpa_pkg::NUM_PAD_W-2:0], 1'b0};
			if (trial >= {1'b0, t.den}) begin
				t.rem = fpa_pkg::DATA_W'(trial - {1'b0, t.den});
				t.quo = {t.quo[fpa_pkg::NUM_PAD_W-2:0], 1'b1};
			end else begin
				t.rem = trial[fpa_pkg::DATA_W-1:0];
				t.quo = {t.quo[fpa_pkg::NUM_PAD_W-2:0], 1'b0};
			end
		end
		return t;
	endfunction

	step_t head;
	step_t stage_sd [fpa_pkg::DIV_STAGES];

	always_comb begin
		head.num = fpa_pkg::NUM_PAD_W'(num);
		head.quo = '0;
		head.rem = '0;
		head.den = den;
	end

	for (genvar k = 0; k < fpa_pkg::DIV_STAGES; k++) begin : g_stage
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					stage_sd[k] <= div_step(head);
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en) begin
					stage_sd[k] <= div_step(stage_sd[k-1]);
				end
			end
		end
	end

	assign quot    = stage_sd[fpa_pkg::DIV_STAGES-1].quo;
	assign rem     = stage_sd[fpa_pkg::DIV_STAGES-1].rem;
	assign den_out = stage_sd[fpa_pkg::DIV_STAGES-1].den;

endmodule

[src/fixed_point_q24_8_alu_unit.sv]
// Q24.8 fixed-point arithmetic unit.
// A request enters on request/request_valid/request_ready and carries an
// operation code and two raw 32-bit operands. Every request gives exactly one
// result on result/result_valid/result_ready, in request order.
// The pipeline has an input stage, an operand preparation stage, one stage per
// two quotient bits of the restoring divider (20 stages for 8 fraction bits)
// and a rounding stage that is also the output register. Every operation takes
// the same path. The multiplier runs beside the first divider stage and its
// product rides along the divider stages.
// One request is accepted per cycle as long as the receiver takes results.
// When result_valid is high and result_ready is low the whole pipeline holds,
// request_ready drops, and nothing is lost or repeated.
// Reset clears all valid bits, so the pipeline comes up empty.
module fixed_point_q24_8_alu_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          request_valid,
	output logic          request_ready,
	input  fpa_pkg::req_t request,
	output logic          result_valid,
	input  logic          result_ready,
	output fpa_pkg::rsp_t result
);

	localparam int D = fpa_pkg::DIV_STAGES;
	localparam int W = fpa_pkg::DATA_W;

	logic en;

	logic          valid_s1;
	fpa_pkg::req_t req_s1;

	logic            valid_s2;
	fpa_pkg::side_t  side_s2;
	logic [W-1:0]    mag_a_s2;
	logic [W-1:0]    mag_b_s2;

	logic                            valid_sd [D];
	fpa_pkg::side_t                  side_sd  [D];
	logic [fpa_pkg::WIDE_W-1:0]      prod_sd  [D];

	logic            valid_q;
	fpa_pkg::rsp_t   rsp_q;

	fpa_pkg::op_t    op1;
	logic signed [W-1:0] a1;
	logic signed [W-1:0] b1;
	logic [W-1:0]    mag_a1;
	logic [W-1:0]    mag_b1;
	fpa_pkg::side_t  side1;

	logic [fpa_pkg::NUM_PAD_W-1:0] quot;
	logic [W-1:0]                  rem;
	logic [W-1:0]                  den_out;

	logic [fpa_pkg::WIDE_W-1:0] mul_q;
	logic [fpa_pkg::WIDE_W-1:0] div_q;
	logic                       div_rnd;
	fpa_pkg::clamp_t            mul_c;
	fpa_pkg::clamp_t            div_c;
	fpa_pkg::side_t             side_l;
	fpa_pkg::rsp_t              rsp_d;

	assign en            = !valid_q || result_ready;
	assign request_ready = en;
	assign result_valid  = valid_q;
	assign result        = rsp_q;

	always_comb begin
		op1    = fpa_pkg::op_t'(req_s1.operation);
		a1     = req_s1.operand_a;
		b1     = req_s1.operand_b;
		mag_a1 = a1[W-1] ? (~a1 + W'(1)) : a1;
		mag_b1 = b1[W-1] ? (~b1 + W'(1)) : b1;
		side1.op  = op1;
		side1.neg = a1[W-1] ^ b1[W-1];
		side1.dz  = (op1 == fpa_pkg::OP_DIV) && (b1 == '0);
		side1.cmp = 1'b0;
		side1.simple = '0;
		case (op1)
			fpa_pkg::OP_ADD:      side1.simple = a1 + b1;
			fpa_pkg::OP_SUB:      side1.simple = a1 - b1;
			fpa_pkg::OP_MIN:      side1.simple = (a1 <= b1) ? a1 : b1;
			fpa_pkg::OP_MAX:      side1.simple = (a1 >= b1) ? a1 : b1;
			fpa_pkg::OP_INC:      side1.simple = a1 + W'(1);
			fpa_pkg::OP_DEC:      side1.simple = a1 - W'(1);
			fpa_pkg::OP_TO_INT:   side1.simple = a1[W-1] ?
				(W'(0) - (mag_a1 >> fpa_pkg::FRAC_BITS)) : (mag_a1 >> fpa_pkg::FRAC_BITS);
			fpa_pkg::OP_FROM_INT: side1.simple = a1 << fpa_pkg::FRAC_BITS;
			fpa_pkg::OP_LT:       side1.cmp = a1 < b1;
			fpa_pkg::OP_GT:       side1.cmp = a1 > b1;
			fpa_pkg::OP_LE:       side1.cmp = a1 <= b1;
			fpa_pkg::OP_GE:       side1.cmp = a1 >= b1;
			fpa_pkg::OP_EQ:       side1.cmp = a1 == b1;
			fpa_pkg::OP_NE:       side1.cmp = a1 != b1;
			default:              side1.simple = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= request_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s1   <= request;
			side_s2  <= side1;
			mag_a_s2 <= mag_a1;
			mag_b_s2 <= mag_b1;
		end
	end

	fpa_div u_div (
		.clk     (clk),
		.en      (en),
		.num     ({mag_a_s2, fpa_pkg::FRAC_BITS'(0)}),
		.den     (mag_b_s2),
		.quot    (quot),
		.rem     (rem),
		.den_out (den_out)
	);

	for (genvar k = 0; k < D; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sd[k] <= 1'b0;
			end else if (en) begin
				valid_sd[k] <= (k == 0) ? valid_s2 : valid_sd[(k == 0) ? 0 : k-1];
			end
		end
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					side_sd[k] <= side_s2;
					prod_sd[k] <= fpa_pkg::WIDE_W'(mag_a_s2) * fpa_pkg::WIDE_W'(mag_b_s2);
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en) begin
					side_sd[k] <= side_sd[k-1];
					prod_sd[k] <= prod_sd[k-1];
				end
			end
		end
	end

	always_comb begin
		side_l  = side_sd[D-1];
		mul_q   = (prod_sd[D-1] + fpa_pkg::ROUND_HALF) >> fpa_pkg::FRAC_BITS;
		div_rnd = {rem, 1'b0} >= {1'b0, den_out};
		div_q   = fpa_pkg::WIDE_W'(quot) + fpa_pkg::WIDE_W'(div_rnd);
		mul_c   = fpa_pkg::clamp_mag(side_l.neg, mul_q);
		div_c   = fpa_pkg::clamp_mag(side_l.neg, div_q);
		rsp_d.compare_true   = side_l.cmp;
		rsp_d.divide_by_zero = side_l.dz;
		rsp_d.saturated      = 1'b0;
		rsp_d.result_value   = side_l.simple;
		case (side_l.op)
			fpa_pkg::OP_MUL: begin
				rsp_d.result_value = mul_c.value;
				rsp_d.saturated    = mul_c.sat;
			end
			fpa_pkg::OP_DIV: begin
				rsp_d.result_value = side_l.dz ? '0 : div_c.value;
				rsp_d.saturated    = !side_l.dz && div_c.sat;
			end
			default: rsp_d.saturated = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_sd[D-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

[src/fpa_chk.sv]
`include "assert_macros.svh"

module fpa_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          request_valid,
	input logic          request_ready,
	input fpa_pkg::req_t request,
	input logic          result_valid,
	input logic          result_ready,
	input fpa_pkg::rsp_t result
);

	`AST_NEXT(a_hold_valid, clk, arst_n, result_valid && !result_ready, result_valid)
	`AST_NEXT(a_hold_data, clk, arst_n, result_valid && !result_ready, $stable(result))
	`AST_NOW(a_cmp_zero, clk, arst_n, result_valid && result.compare_true, result.result_value == '0)
	`AST_NOW(a_dz_clean, clk, arst_n, result_valid && result.divide_by_zero,
		!result.saturated && !result.compare_true && result.result_value == '0)
	`AST_NOW(a_stall_block, clk, arst_n, result_valid && !result_ready, !request_ready)

endmodule

bind fixed_point_q24_8_alu_unit fpa_chk u_fpa_chk (.*);

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           request_valid = 1'b0;
	logic           request_ready;
	fpa_pkg::req_t  request = '0;
	logic           result_valid;
	logic           result_ready = 1'b0;
	fpa_pkg::rsp_t  result;

	fpa_pkg::req_t  pending_requests[$];
	fpa_pkg::rsp_t  expected_results[$];
	int    mismatch_count = 0;
	bit    request_taken = 1'b0;
	bit    hold_sender = 1'b0;
	bit    quiet_stretch = 1'b0;

	fixed_point_q24_8_alu_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.request_valid(request_valid),
		.request_ready(request_ready),
		.request(request),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always #10 clk = ~clk;

	function automatic fpa_pkg::rsp_t saturate_magnitude(input bit neg, input logic [63:0] mag);
		fpa_pkg::rsp_t r;
		r = '0;
		if (!neg) begin
			if (mag > 64'h7FFF_FFFF) begin
				r.saturated = 1'b1;
				r.result_value = 32'h7FFF_FFFF;
			end else begin
				r.result_value = mag[31:0];
			end
		end else begin
			if (mag > 64'h8000_0000) begin
				r.saturated = 1'b1;
				r.result_value = 32'h8000_0000;
			end else begin
				r.result_value = 32'd0 - mag[31:0];
			end
		end
		return r;
	endfunction

	function automatic fpa_pkg::rsp_t fixed_point_result(input fpa_pkg::req_t req);
		fpa_pkg::rsp_t r;
		longint a, b, p;
		logic [63:0] m, n, d, q;
		r = '0;
		a = longint'(req.operand_a);
		b = longint'(req.operand_b);
		case (fpa_pkg::op_t'(req.operation))
			fpa_pkg::OP_ADD: r.result_value = req.operand_a + req.operand_b;
			fpa_pkg::OP_SUB: r.result_value = req.operand_a - req.operand_b;
			fpa_pkg::OP_MUL: begin
				p = a * b;
				m = (p < 0) ? 64'(-p) : 64'(p);
				q = (m + 64'd128) >> 8;
				r = saturate_magnitude(p < 0, q);
			end
			fpa_pkg::OP_DIV: begin
				if (b == 0) begin
					r.divide_by_zero = 1'b1;
				end else begin
					n = ((a < 0) ? 64'(-a) : 64'(a)) << 8;
					d = (b < 0) ? 64'(-b) : 64'(b);
					q = (2 * n + d) / (2 * d);
					r = saturate_magnitude((a < 0) != (b < 0), q);
				end
			end
			fpa_pkg::OP_LT: r.compare_true = a < b;
			fpa_pkg::OP_GT: r.compare_true = a > b;
			fpa_pkg::OP_LE: r.compare_true = a <= b;
			fpa_pkg::OP_GE: r.compare_true = a >= b;
			fpa_pkg::OP_EQ: r.compare_true = a == b;
			fpa_pkg::OP_NE: r.compare_true = a != b;
			fpa_pkg::OP_MIN: r.result_value = (a <= b) ? req.operand_a : req.operand_b;
			fpa_pkg::OP_MAX: r.result_value = (a >= b) ? req.operand_a : req.operand_b;
			fpa_pkg::OP_INC: r.result_value = req.operand_a + 32'sd1;
			fpa_pkg::OP_DEC: r.result_value = req.operand_a - 32'sd1;
			fpa_pkg::OP_TO_INT: r.result_value = 32'(a / 256);
			default: r.result_value = req.operand_a << 8;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] random_operand();
		case ($urandom_range(0, 5))
			0: return 32'($signed($urandom_range(0, 4095)) - 2048);
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 300)
				: 32'h8000_0000 + $urandom_range(0, 300);
			2: return 32'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
			3: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom())};
			default: return $urandom();
		endcase
	endfunction

	task automatic queue_request(input fpa_pkg::op_t op, input logic [31:0] a,
			input logic [31:0] b);
		fpa_pkg::req_t req;
		req.operation = op;
		req.operand_a = a;
		req.operand_b = b;
		pending_requests.push_back(req);
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!request_valid || request_taken) begin
				if (pending_requests.size() > 0 && !hold_sender &&
						(quiet_stretch || $urandom_range(0, 99) >= 6)) begin
					request_valid <= 1'b1;
					request <= pending_requests.pop_front();
				end else begin
					request_valid <= 1'b0;
				end
			end
			result_ready <= quiet_stretch || $urandom_range(0, 99) >= 6;
		end
	end

	always @(posedge clk) begin
		fpa_pkg::rsp_t exp_rsp;
		request_taken = request_valid && request_ready;
		if (request_valid && request_ready)
			expected_results.push_back(fixed_point_result(request));
		if (result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("Unexpected result %h", result);
			end else begin
				exp_rsp = expected_results.pop_front();
				if (result !== exp_rsp) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("Mismatch: expected %h/%b%b%b got %h/%b%b%b",
							exp_rsp.result_value, exp_rsp.compare_true,
							exp_rsp.saturated, exp_rsp.divide_by_zero,
							result.result_value, result.compare_true,
							result.saturated, result.divide_by_zero);
				end
			end
		end
	end

	initial begin
		logic [31:0] edge_values[6];
		edge_values = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h100, 32'h80};
		for (int op = 0; op < 16; op++)
			queue_request(fpa_pkg::op_t'(op), edge_values[op % 6], edge_values[(op + 2) % 6]);
		queue_request(fpa_pkg::OP_DIV, 32'h500, 32'h0);
		queue_request(fpa_pkg::OP_DIV, 32'h8000_0000, 32'h0);
		queue_request(fpa_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
		queue_request(fpa_pkg::OP_MUL, 32'h180, 32'h1);
		queue_request(fpa_pkg::OP_MUL, 32'hFFFF_FE80, 32'h1);
		queue_request(fpa_pkg::OP_DIV, 32'h8000_0000, 32'h1);
		queue_request(fpa_pkg::OP_MIN, 32'h55, 32'h55);
		queue_request(fpa_pkg::OP_TO_INT, 32'hFFFF_FF01, 32'h0);
		queue_request(fpa_pkg::OP_EQ, 32'h1234, 32'h1234);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < 1350; i++) begin
			if (i == 300) begin
				wait (pending_requests.size() == 0);
				hold_sender = 1'b1;
				wait (!request_valid && expected_results.size() == 0);
				hold_sender = 1'b0;
			end
			if (i == 600) begin
				wait (pending_requests.size() == 0);
				quiet_stretch = 1'b1;
			end
			if (i == 900) quiet_stretch = 1'b0;
			queue_request(fpa_pkg::op_t'($urandom_range(0, 15)), random_operand(),
				($urandom_range(0, 19) == 0) ? 32'h0 : random_operand());
			if (pending_requests.size() > 50) @(posedge clk);
		end
		wait (pending_requests.size() == 0 && !request_valid);
		wait (expected_results.size() == 0);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#2ms;
		$display("FAILURE");
		$finish;
	end

endmodule
